// ----- rtl/dvl_pkg.sv -----
// shared types and codes for the delta varint list decoder
// no dependencies; imported by every module of the block
package dvl_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned POS_W    = 3;
	localparam int unsigned PAYLD_W  = 7;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_VALUE    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FINAL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERLONG = 3'd4;

	// byte index that holds the top payload bits of a 32-bit varint
	localparam logic [POS_W-1:0] POS_LAST = 3'd4;

	typedef enum logic {
		PH_COUNT,
		PH_DELTA
	} phase_t;

	// one record per input byte that produces results; a truncation
	// result may follow the first one
	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0] status;
		logic                has_trunc;
	} rec_t;

endpackage

// ----- rtl/dvl_front.sv -----
// front end: accepts bytes, assembles varints, tracks list state
// depends on dvl_pkg; feeds result records into dvl_queue
module dvl_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    data_byte,
	input  logic          buffer_end,
	output logic          full,
	input  logic          q_full,
	output logic          q_push,
	output dvl_pkg::rec_t q_rec
);
	import dvl_pkg::*;

	phase_t              phase_q, phase_d;
	logic [VALUE_W-1:0]  part_q, part_d;
	logic [POS_W-1:0]    bpos_q, bpos_d;
	logic [VALUE_W-1:0]  rem_q, rem_d;
	logic [VALUE_W-1:0]  sum_q, sum_d;

	logic                accept;
	logic                more;
	logic [POS_W-1:0]    pos;
	logic [4:0]          shamt;
	logic [VALUE_W-1:0]  merged;
	logic [VALUE_W-1:0]  sum_add;
	logic [VALUE_W-1:0]  rem_dec;
	logic                emit;
	logic                empty_list;
	rec_t                rec;

	assign accept  = push && !q_full;
	assign full    = q_full;
	assign more    = data_byte[7];
	assign pos     = (bpos_q >= POS_LAST) ? POS_LAST : bpos_q;
	assign merged  = part_q | ({25'd0, data_byte[PAYLD_W-1:0]} << shamt);
	assign sum_add = sum_q + merged;
	assign rem_dec = rem_q - 32'd1;
	assign q_push  = accept && emit;
	assign q_rec   = rec;

	always_comb begin
		unique case (pos)
			3'd0:    shamt = 5'd0;
			3'd1:    shamt = 5'd7;
			3'd2:    shamt = 5'd14;
			3'd3:    shamt = 5'd21;
			default: shamt = 5'd28;
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		part_d     = part_q;
		bpos_d     = bpos_q;
		rem_d      = rem_q;
		sum_d      = sum_q;
		emit       = 1'b0;
		empty_list = 1'b0;
		rec        = '0;
		if ((bpos_q >= POS_LAST) && more) begin
			// continuation bit on the fifth byte
			phase_d    = PH_COUNT;
			part_d     = '0;
			bpos_d     = '0;
			rem_d      = '0;
			sum_d      = '0;
			emit       = 1'b1;
			rec.status = ST_OVERLONG;
		end else begin
			part_d = merged;
			if (more) begin
				bpos_d = pos + 3'd1;
			end else begin
				part_d = '0;
				bpos_d = '0;
				if (phase_q == PH_COUNT) begin
					if (merged == '0) begin
						empty_list = 1'b1;
						rem_d      = '0;
						sum_d      = '0;
						emit       = 1'b1;
						rec.status = ST_EMPTY;
					end else begin
						phase_d = PH_DELTA;
						rem_d   = merged;
						sum_d   = '0;
					end
				end else begin
					emit      = 1'b1;
					rec.value = sum_add;
					sum_d     = sum_add;
					rem_d     = rem_dec;
					if (rem_dec == '0) begin
						rec.status = ST_FINAL;
						phase_d    = PH_COUNT;
						sum_d      = '0;
					end else begin
						rec.status = ST_VALUE;
					end
				end
			end
			// buffer ends with a list still open
			if (!empty_list && buffer_end && ((phase_d != PH_COUNT) || (bpos_d != '0))) begin
				phase_d = PH_COUNT;
				part_d  = '0;
				bpos_d  = '0;
				rem_d   = '0;
				sum_d   = '0;
				if (emit) begin
					rec.has_trunc = 1'b1;
				end else begin
					emit       = 1'b1;
					rec.status = ST_TRUNC;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			bpos_q <= '0;
			rem_q  <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			part_q <= part_d;
			bpos_q <= bpos_d;
			rem_q  <= rem_d;
			sum_q  <= sum_d;
		end
	end

endmodule

// ----- rtl/dvl_queue.sv -----
// short record queue between front and back end
// depends on dvl_pkg for the record type
module dvl_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  dvl_pkg::rec_t wr_rec,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output dvl_pkg::rec_t rd_rec
);
	import dvl_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_END = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (cnt_q == CNT_MAX);
	assign rd_valid = (cnt_q != '0);
	assign rd_rec   = mem_q[rd_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_q <= (wr_q == PTR_END) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_q <= (rd_q == PTR_END) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (!do_wr && do_rd) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/dvl_back.sv -----
// back end: expands records into result beats, holds the output register
// depends on dvl_pkg; drains dvl_queue
module dvl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  dvl_pkg::rec_t q_rec,
	output logic          q_pop,
	output logic          empty,
	input  logic          pop,
	output logic [31:0]   decoded_value,
	output logic [2:0]    status,
	output logic          last_of_run
);
	import dvl_pkg::*;

	logic                valid_q;
	logic                pend_q;
	logic [VALUE_W-1:0]  value_q;
	logic [STATUS_W-1:0] status_q;
	logic                last_q;
	logic                load;

	assign load          = !valid_q || pop;
	assign q_pop         = load && !pend_q && q_valid;
	assign empty         = !valid_q;
	assign decoded_value = value_q;
	assign status        = status_q;
	assign last_of_run   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= q_valid;
				pend_q  <= q_valid && q_rec.has_trunc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				value_q  <= '0;
				status_q <= ST_TRUNC;
				last_q   <= 1'b1;
			end else if (q_valid) begin
				value_q  <= q_rec.value;
				status_q <= q_rec.status;
				last_q   <= !q_rec.has_trunc;
			end
		end
	end

endmodule

// ----- rtl/delta_varint_list_decoder_top.sv -----
// delta varint list decoder: one byte per cycle in while full is low, one result
// beat per cycle out while pop is high; a byte's record is written into the queue
// and then loaded into the output register; a byte with two results gives two beats
// byte rate rests on a combinational varint merge and 32-bit sum/count update
// reset: arst_n low clears list state, queue and output valid; empty goes high
// depends on dvl_pkg, dvl_front, dvl_queue, dvl_back
module delta_varint_list_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte side
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	// result side
	output logic        empty,
	input  logic        pop,
	output logic [31:0] decoded_value,
	output logic [2:0]  status,
	output logic        last_of_run
);
	import dvl_pkg::*;

	// record path from front end into the queue
	logic q_full;
	logic q_push;
	rec_t q_wr_rec;

	// record path from the queue into the back end
	logic q_pop;
	logic q_valid;
	rec_t q_rd_rec;

	// front end decodes each byte in the cycle it is taken; it stalls only
	// when the record queue is full, never on the result side directly
	dvl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_byte  (data_byte),
		.buffer_end (buffer_end),
		.full       (full),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_rec      (q_wr_rec)
	);

	// decouples the byte rate from result drain; bytes with no result skip it
	dvl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_rec   (q_wr_rec),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_rec   (q_rd_rec)
	);

	// back end splits a value-plus-truncation record into two beats and
	// refills the output register in the cycle the current beat is popped
	dvl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_rec         (q_rd_rec),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.decoded_value (decoded_value),
		.status        (status),
		.last_of_run   (last_of_run)
	);

endmodule

// ----- rtl/dvl_checker.sv -----
// port-level checks for the delta varint list decoder
// depends on dvl_pkg; bound to delta_varint_list_decoder_top
module dvl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [7:0]  data_byte,
	input logic        buffer_end,
	input logic        empty,
	input logic        pop,
	input logic [31:0] decoded_value,
	input logic [2:0]  status,
	input logic        last_of_run
);
	import dvl_pkg::*;

	// output valid flag is cleared by reset; checked with a non-overlapping implication so the
	// first reset edge, before any clear took effect, is not sampled
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result visible during reset");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == ST_VALUE || status == ST_FINAL || status == ST_EMPTY ||
			status == ST_TRUNC || status == ST_OVERLONG))
		else $error("undefined status code");

	// non-value results carry a zero value
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ST_EMPTY || status == ST_TRUNC || status == ST_OVERLONG))
		|-> (decoded_value == '0))
		else $error("nonzero value on a non-value result");

	// only a plain value beat can be followed by another beat of the same byte
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_VALUE) |-> last_of_run)
		else $error("terminal result not marked last");

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(decoded_value) && $stable(status) &&
			$stable(last_of_run)))
		else $error("stalled result changed");

endmodule

bind delta_varint_list_decoder_top dvl_checker u_dvl_checker (.*);
